@@ sv/etween_pkg.sv @@
// Shared types and codes for the eased tween channel.
`timescale 1ns / 1ps
`default_nettype none

package etween_pkg;

   localparam int TIME_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [31:0] LC_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      CSR_DELAY    = 3'd0,
      CSR_DURATION = 3'd1,
      CSR_REPEAT   = 3'd2,
      CSR_FOREVER  = 3'd3,
      CSR_STYLE    = 3'd4,
      CSR_EASING   = 3'd5,
      CSR_START    = 3'd6,
      CSR_END      = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_PAUSE   = 3'd1,
      REQ_RESUME  = 3'd2,
      REQ_RESTART = 3'd3,
      REQ_CANCEL  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      CAUSE_EXPLICIT    = 2'd0,
      CAUSE_REPLACED    = 2'd1,
      CAUSE_INVALIDATED = 2'd2,
      CAUSE_REJECTED    = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_INVALID  = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PLAY_PLAYING   = 2'd0,
      PLAY_PAUSED    = 2'd1,
      PLAY_COMPLETED = 2'd2,
      PLAY_CANCELLED = 2'd3
   } play_type;

   typedef enum logic [2:0] {
      EASE_LINEAR       = 3'd0,
      EASE_IN_QUAD      = 3'd1,
      EASE_OUT_QUAD     = 3'd2,
      EASE_INOUT_QUAD   = 3'd3,
      EASE_IN_CUBIC     = 3'd4,
      EASE_OUT_CUBIC    = 3'd5,
      EASE_INOUT_CUBIC  = 3'd6
   } ease_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_DIV_LT = 4'd1,
      PH_DIV_D  = 4'd2,
      PH_CROSS  = 4'd3,
      PH_DECIDE = 4'd4,
      PH_FRAC   = 4'd5,
      PH_SQUARE = 4'd6,
      PH_CUBE   = 4'd7,
      PH_INTERP = 4'd8,
      PH_FIN    = 4'd9
   } phase_type;

endpackage

`default_nettype wire

@@ sv/eased_tween_channel.sv @@
// Eased tween channel: delay, looping, easing and interpolation of four Q8.8 values.
// Pause, resume, restart, cancel and ticks that stay in the delay answer without the dividers.
// A tick that moves the loop uses two bit-serial divides, one bit-serial fraction divide
// and a bit-serial multiplier used for easing and the four components.
// One request at a time; a new request is taken while the last response waits.
// Synchronous reset restores config, channel state, phase, status and rsp_valid only.
`timescale 1ns / 1ps
`default_nettype none

module eased_tween_channel
   import etween_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_type,
   input  wire logic [31:0]            req_delta_ticks,
   input  wire logic [1:0]             req_cancel_cause,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [1:0]                  rsp_play_state,
   output logic [31:0]                 rsp_loop_number,
   output logic [31:0]                 rsp_loop_position,
   output logic                        rsp_going_back,
   output logic signed [15:0]          rsp_value_x,
   output logic signed [15:0]          rsp_value_y,
   output logic signed [15:0]          rsp_value_z,
   output logic signed [15:0]          rsp_value_w,
   output logic [2:0]                  rsp_stop_cause,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TW  = TIME_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int QW  = (TW > F) ? TW : F;
   localparam int AW  = (F + 2 > 17) ? F + 2 : 17;
   localparam int BW  = F + 1;
   localparam int PW  = AW + BW;
   localparam int CW  = $clog2(QW + 1);
   localparam int MCW = $clog2(BW + 1);
   localparam int XW  = (TW + 1 > 33) ? TW + 1 : 33;
   localparam logic [BW-1:0] QONE = {1'b1, {F{1'b0}}};

   // configuration
   logic [31:0] delay_ticks_ff, delay_ticks_in;
   logic [31:0] duration_ff, duration_in;
   logic [15:0] repeat_ff, repeat_in;
   logic        forever_ff, forever_in;
   logic        style_ff, style_in;
   logic [2:0]  easing_ff, easing_in;
   logic [63:0] start_ff, start_in;
   logic [63:0] end_ff, end_in;

   // channel state
   play_type    playback_ff, playback_in;
   logic [TW-1:0] delay_spent_ff, delay_spent_in;
   logic [TW-1:0] loop_time_ff, loop_time_in;
   logic [31:0] loop_count_ff, loop_count_in;
   logic        reverse_ff, reverse_in;
   logic [63:0] cur_value_ff, cur_value_in;
   logic [2:0]  cancel_rec_ff, cancel_rec_in;

   // work registers
   phase_type   phase_ff, phase_in;
   status_type  status_ff, status_in;
   logic [TW-1:0] spent_ff, spent_in;
   logic [TW-1:0] d_ff, d_in;
   logic [TW-1:0] q0_ff, q0_in;
   logic [TW-1:0] lt_ff, lt_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW:0]   crossed_ff, crossed_in;
   logic [TW-1:0] newrem_ff, newrem_in;
   logic [F-1:0]  t_ff, t_in;
   logic [BW-1:0] base_ff, base_in;
   logic [BW-1:0] e_ff, e_in;
   logic signed [AW-1:0] mul_a_ff, mul_a_in;
   logic [BW-1:0] mul_b_ff, mul_b_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic [MCW-1:0] mcnt_ff, mcnt_in;
   logic [1:0]  comp_ff, comp_in;
   logic [63:0] newval_ff, newval_in;

   // response
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [1:0]  rsp_play_ff, rsp_play_in;
   logic [31:0] rsp_lnum_ff, rsp_lnum_in;
   logic [31:0] rsp_lpos_ff, rsp_lpos_in;
   logic        rsp_back_ff, rsp_back_in;
   logic [63:0] rsp_val_ff, rsp_val_in;
   logic [2:0]  rsp_cause_ff, rsp_cause_in;

   // combinational helpers
   logic [TW-1:0] dur_w;
   logic [TW:0]   div_sh;
   logic          div_ge;
   logic [TW-1:0] div_rem_nx;
   logic [QW-1:0] div_quo_nx;
   logic          div_last;
   logic          frac_last;
   logic signed [PW-1:0] acc_nx;
   logic          mul_last;
   logic [F-1:0]  t_nx;
   logic [BW-1:0] u_nx;
   logic [BW-1:0] x_nx;
   logic [BW-1:0] p_f, p_fm1, p_f1;
   logic [BW-1:0] e_fin;
   logic [1:0]    ld_k;
   logic [63:0]   from_val, to_val;
   logic [15:0]   ld_from, ld_to, cur_from, new16;
   logic signed [16:0] ld_diff;
   logic          req_acc;
   logic [TW-1:0] d_req, dly_w, left_w;
   logic [32:0]   fin_left;
   logic [31:0]   lc_new;
   logic [TW-1:0] gap_w;
   logic          carry_w;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (phase_ff != PH_IDLE);

   assign dur_w = (TW'(duration_ff) == '0) ? TW'(1) : TW'(duration_ff);

   // restoring divider step, dividend bits shift out of the quotient register
   assign div_sh     = {rem_ff, quo_ff[QW-1]};
   assign div_ge     = (div_sh >= {1'b0, dur_w});
   assign div_rem_nx = div_ge ? TW'(div_sh - {1'b0, dur_w}) : div_sh[TW-1:0];
   assign div_quo_nx = {quo_ff[QW-2:0], div_ge};
   assign div_last   = (cnt_ff == CW'(TW - 1));
   assign frac_last  = (cnt_ff == CW'(F - 1));

   // shift-add multiplier, multiplier bits MSB first
   assign acc_nx   = (acc_ff <<< 1) +
                     (mul_b_ff[BW-1] ? PW'(mul_a_ff) : PW'(0));
   assign mul_last = (mcnt_ff == MCW'(BW - 1));

   assign t_nx = div_quo_nx[F-1:0];
   assign u_nx = QONE - {1'b0, t_nx};
   assign x_nx = BW'({u_nx, 1'b0});

   assign p_f   = acc_nx[F +: BW];
   assign p_fm1 = acc_nx[F-1 +: BW];
   assign p_f1  = acc_nx[F+1 +: BW];

   always_comb begin
      unique case (ease_type'(easing_ff))
         EASE_IN_QUAD:     e_fin = p_f;
         EASE_OUT_QUAD:    e_fin = QONE - p_f;
         EASE_INOUT_QUAD:  e_fin = t_ff[F-1] ? QONE - p_f1 : p_fm1;
         EASE_IN_CUBIC:    e_fin = p_f;
         EASE_OUT_CUBIC:   e_fin = QONE - p_f;
         EASE_INOUT_CUBIC: e_fin = t_ff[F-1] ? QONE - p_f1 : BW'(p_f << 2);
         default:          e_fin = p_f;
      endcase
   end

   assign from_val = reverse_ff ? end_ff : start_ff;
   assign to_val   = reverse_ff ? start_ff : end_ff;
   assign ld_k     = (phase_ff == PH_INTERP) ? comp_ff + 2'd1 : 2'd0;
   assign ld_from  = from_val[{ld_k, 4'b0000} +: 16];
   assign ld_to    = to_val[{ld_k, 4'b0000} +: 16];
   assign ld_diff  = $signed({ld_to[15], ld_to}) - $signed({ld_from[15], ld_from});
   assign cur_from = from_val[{comp_ff, 4'b0000} +: 16];
   // floor of the product over ONE, low 16 bits are all the sum needs
   assign new16    = cur_from + acc_nx[F +: 16];

   assign d_req  = TW'(req_delta_ticks);
   assign dly_w  = TW'(delay_ticks_ff);
   assign left_w = dly_w - delay_spent_ff;

   assign fin_left = (loop_count_ff <= 32'(repeat_ff)) ?
                     (33'(repeat_ff) + 33'd1 - 33'(loop_count_ff)) : 33'd0;
   assign lc_new   = loop_count_ff + 32'(crossed_ff);

   assign gap_w   = dur_w - rem_ff;
   assign carry_w = (lt_ff >= gap_w);

   always_comb begin
      delay_ticks_in = delay_ticks_ff;
      duration_in    = duration_ff;
      repeat_in      = repeat_ff;
      forever_in     = forever_ff;
      style_in       = style_ff;
      easing_in      = easing_ff;
      start_in       = start_ff;
      end_in         = end_ff;

      playback_in    = playback_ff;
      delay_spent_in = delay_spent_ff;
      loop_time_in   = loop_time_ff;
      loop_count_in  = loop_count_ff;
      reverse_in     = reverse_ff;
      cur_value_in   = cur_value_ff;
      cancel_rec_in  = cancel_rec_ff;

      phase_in   = phase_ff;
      status_in  = status_ff;
      spent_in   = spent_ff;
      d_in       = d_ff;
      q0_in      = q0_ff;
      lt_in      = lt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      crossed_in = crossed_ff;
      newrem_in  = newrem_ff;
      t_in       = t_ff;
      base_in    = base_ff;
      e_in       = e_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      acc_in     = acc_ff;
      mcnt_in    = mcnt_ff;
      comp_in    = comp_ff;
      newval_in  = newval_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_play_in   = rsp_play_ff;
      rsp_lnum_in   = rsp_lnum_ff;
      rsp_lpos_in   = rsp_lpos_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_cause_in  = rsp_cause_ff;

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY:    delay_ticks_in = csr_wdata[31:0];
            CSR_DURATION: duration_in    = csr_wdata[31:0];
            CSR_REPEAT:   repeat_in      = csr_wdata[15:0];
            CSR_FOREVER:  forever_in     = csr_wdata[0];
            CSR_STYLE:    style_in       = csr_wdata[0];
            CSR_EASING:   easing_in      = csr_wdata[2:0];
            CSR_START:    start_in       = csr_wdata;
            CSR_END:      end_in         = csr_wdata;
         endcase
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_acc) begin
               status_in = STAT_OK;
               phase_in  = PH_FIN;
               case (req_code_type'(req_type))
                  REQ_TICK: begin
                     if (playback_ff == PLAY_PLAYING) begin
                        if (delay_spent_ff < dly_w && d_req <= left_w) begin
                           delay_spent_in = delay_spent_ff + d_req;
                        end else begin
                           if (delay_spent_ff < dly_w) begin
                              spent_in = dly_w;
                              d_in     = d_req - left_w;
                           end else begin
                              spent_in = delay_spent_ff;
                              d_in     = d_req;
                           end
                           if (delay_spent_ff >= dly_w && d_req == '0) begin
                              delay_spent_in = delay_spent_ff;
                           end else begin
                              rem_in   = '0;
                              quo_in   = QW'(loop_time_ff) << (QW - TW);
                              cnt_in   = '0;
                              phase_in = PH_DIV_LT;
                           end
                        end
                     end
                  end
                  REQ_PAUSE: begin
                     if (playback_ff == PLAY_PLAYING) playback_in = PLAY_PAUSED;
                     else status_in = STAT_INVALID;
                  end
                  REQ_RESUME: begin
                     if (playback_ff == PLAY_PAUSED) playback_in = PLAY_PLAYING;
                     else status_in = STAT_INVALID;
                  end
                  REQ_RESTART: begin
                     playback_in    = PLAY_PLAYING;
                     delay_spent_in = '0;
                     loop_time_in   = '0;
                     loop_count_in  = '0;
                     reverse_in     = 1'b0;
                     cur_value_in   = start_ff;
                     cancel_rec_in  = '0;
                  end
                  REQ_CANCEL: begin
                     if (playback_ff == PLAY_CANCELLED ||
                         (playback_ff == PLAY_COMPLETED &&
                          (cause_type'(req_cancel_cause) == CAUSE_EXPLICIT ||
                           cause_type'(req_cancel_cause) == CAUSE_REPLACED))) begin
                        status_in = STAT_INVALID;
                     end else begin
                        playback_in   = PLAY_CANCELLED;
                        cancel_rec_in = 3'({1'b0, req_cancel_cause}) + 3'd1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         PH_DIV_LT: begin
            rem_in = div_rem_nx;
            quo_in = div_quo_nx;
            cnt_in = cnt_ff + CW'(1);
            if (div_last) begin
               q0_in    = div_quo_nx[TW-1:0];
               lt_in    = div_rem_nx;
               rem_in   = '0;
               quo_in   = QW'(d_ff) << (QW - TW);
               cnt_in   = '0;
               phase_in = PH_DIV_D;
            end
         end

         PH_DIV_D: begin
            rem_in = div_rem_nx;
            quo_in = div_quo_nx;
            cnt_in = cnt_ff + CW'(1);
            if (div_last) phase_in = PH_CROSS;
         end

         PH_CROSS: begin
            // quotient and remainder of delta now sit in quo_ff and rem_ff
            newrem_in  = carry_w ? lt_ff - gap_w : lt_ff + rem_ff;
            crossed_in = (TW+1)'(q0_ff) + (TW+1)'(quo_ff[TW-1:0]) + (TW+1)'(carry_w);
            phase_in   = PH_DECIDE;
         end

         PH_DECIDE: begin
            if (!forever_ff && XW'(crossed_ff) >= XW'(fin_left)) begin
               delay_spent_in = spent_ff;
               loop_count_in  = 32'(repeat_ff);
               reverse_in     = style_ff && repeat_ff[0];
               loop_time_in   = dur_w;
               cur_value_in   = (style_ff && repeat_ff[0]) ? start_ff : end_ff;
               playback_in    = PLAY_COMPLETED;
               cancel_rec_in  = '0;
               phase_in       = PH_FIN;
            end else if (XW'(crossed_ff) > XW'(LC_MAX - loop_count_ff)) begin
               status_in = STAT_OVERFLOW;
               phase_in  = PH_FIN;
            end else begin
               delay_spent_in = spent_ff;
               loop_count_in  = lc_new;
               loop_time_in   = newrem_ff;
               reverse_in     = style_ff && lc_new[0];
               rem_in         = newrem_ff;
               quo_in         = '0;
               cnt_in         = '0;
               phase_in       = PH_FRAC;
            end
         end

         PH_FRAC: begin
            rem_in = div_rem_nx;
            quo_in = div_quo_nx;
            cnt_in = cnt_ff + CW'(1);
            if (frac_last) begin
               t_in    = t_nx;
               acc_in  = '0;
               mcnt_in = '0;
               unique case (ease_type'(easing_ff))
                  EASE_OUT_QUAD, EASE_OUT_CUBIC: base_in = u_nx;
                  EASE_INOUT_QUAD, EASE_INOUT_CUBIC:
                     base_in = t_nx[F-1] ? x_nx : {1'b0, t_nx};
                  default: base_in = {1'b0, t_nx};
               endcase
               if (ease_type'(easing_ff) == EASE_LINEAR || easing_ff == 3'd7) begin
                  e_in     = {1'b0, t_nx};
                  mul_a_in = AW'(ld_diff);
                  mul_b_in = {1'b0, t_nx};
                  comp_in  = '0;
                  phase_in = PH_INTERP;
               end else begin
                  unique case (ease_type'(easing_ff))
                     EASE_OUT_QUAD, EASE_OUT_CUBIC: begin
                        mul_a_in = AW'(u_nx);
                        mul_b_in = u_nx;
                     end
                     EASE_INOUT_QUAD, EASE_INOUT_CUBIC: begin
                        mul_a_in = t_nx[F-1] ? AW'(x_nx) : AW'(t_nx);
                        mul_b_in = t_nx[F-1] ? x_nx : {1'b0, t_nx};
                     end
                     default: begin
                        mul_a_in = AW'(t_nx);
                        mul_b_in = {1'b0, t_nx};
                     end
                  endcase
                  phase_in = PH_SQUARE;
               end
            end
         end

         PH_SQUARE: begin
            acc_in   = acc_nx;
            mul_b_in = {mul_b_ff[BW-2:0], 1'b0};
            mcnt_in  = mcnt_ff + MCW'(1);
            if (mul_last) begin
               acc_in  = '0;
               mcnt_in = '0;
               if (ease_type'(easing_ff) == EASE_IN_CUBIC ||
                   ease_type'(easing_ff) == EASE_OUT_CUBIC ||
                   ease_type'(easing_ff) == EASE_INOUT_CUBIC) begin
                  mul_a_in = AW'(p_f);
                  mul_b_in = base_ff;
                  phase_in = PH_CUBE;
               end else begin
                  e_in     = e_fin;
                  mul_a_in = AW'(ld_diff);
                  mul_b_in = e_fin;
                  comp_in  = '0;
                  phase_in = PH_INTERP;
               end
            end
         end

         PH_CUBE: begin
            acc_in   = acc_nx;
            mul_b_in = {mul_b_ff[BW-2:0], 1'b0};
            mcnt_in  = mcnt_ff + MCW'(1);
            if (mul_last) begin
               acc_in   = '0;
               mcnt_in  = '0;
               e_in     = e_fin;
               mul_a_in = AW'(ld_diff);
               mul_b_in = e_fin;
               comp_in  = '0;
               phase_in = PH_INTERP;
            end
         end

         PH_INTERP: begin
            acc_in   = acc_nx;
            mul_b_in = {mul_b_ff[BW-2:0], 1'b0};
            mcnt_in  = mcnt_ff + MCW'(1);
            if (mul_last) begin
               newval_in = {new16, newval_ff[63:16]};
               acc_in    = '0;
               mcnt_in   = '0;
               if (comp_ff == 2'd3) begin
                  cur_value_in = {new16, newval_ff[63:16]};
                  phase_in     = PH_FIN;
               end else begin
                  mul_a_in = AW'(ld_diff);
                  mul_b_in = e_ff;
                  comp_in  = comp_ff + 2'd1;
               end
            end
         end

         PH_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_play_in   = playback_ff;
               rsp_lnum_in   = loop_count_ff;
               rsp_lpos_in   = 32'(loop_time_ff);
               rsp_back_in   = reverse_ff;
               rsp_val_in    = cur_value_ff;
               rsp_cause_in  = cancel_rec_ff;
               phase_in      = PH_IDLE;
            end
         end

         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= '0;
         duration_ff    <= 32'd1;
         repeat_ff      <= '0;
         forever_ff     <= 1'b0;
         style_ff       <= 1'b0;
         easing_ff      <= EASE_LINEAR;
         start_ff       <= '0;
         end_ff         <= '0;
         playback_ff    <= PLAY_PLAYING;
         delay_spent_ff <= '0;
         loop_time_ff   <= '0;
         loop_count_ff  <= '0;
         reverse_ff     <= 1'b0;
         cur_value_ff   <= '0;
         cancel_rec_ff  <= '0;
         phase_ff       <= PH_IDLE;
         status_ff      <= STAT_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         delay_ticks_ff <= delay_ticks_in;
         duration_ff    <= duration_in;
         repeat_ff      <= repeat_in;
         forever_ff     <= forever_in;
         style_ff       <= style_in;
         easing_ff      <= easing_in;
         start_ff       <= start_in;
         end_ff         <= end_in;
         playback_ff    <= playback_in;
         delay_spent_ff <= delay_spent_in;
         loop_time_ff   <= loop_time_in;
         loop_count_ff  <= loop_count_in;
         reverse_ff     <= reverse_in;
         cur_value_ff   <= cur_value_in;
         cancel_rec_ff  <= cancel_rec_in;
         phase_ff       <= phase_in;
         status_ff      <= status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spent_ff     <= spent_in;
      d_ff         <= d_in;
      q0_ff        <= q0_in;
      lt_ff        <= lt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      crossed_ff   <= crossed_in;
      newrem_ff    <= newrem_in;
      t_ff         <= t_in;
      base_ff      <= base_in;
      e_ff         <= e_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      acc_ff       <= acc_in;
      mcnt_ff      <= mcnt_in;
      comp_ff      <= comp_in;
      newval_ff    <= newval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_play_ff  <= rsp_play_in;
      rsp_lnum_ff  <= rsp_lnum_in;
      rsp_lpos_ff  <= rsp_lpos_in;
      rsp_back_ff  <= rsp_back_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_play_state    = rsp_play_ff;
   assign rsp_loop_number   = rsp_lnum_ff;
   assign rsp_loop_position = rsp_lpos_ff;
   assign rsp_going_back    = rsp_back_ff;
   assign rsp_value_x       = rsp_val_ff[15:0];
   assign rsp_value_y       = rsp_val_ff[31:16];
   assign rsp_value_z       = rsp_val_ff[47:32];
   assign rsp_value_w       = rsp_val_ff[63:48];
   assign rsp_stop_cause    = rsp_cause_ff;

endmodule

`default_nettype wire
